/* rtl/mqtt_fhp_pkg.sv */
// Shared types, codes and the per-type length rule for the MQTT fixed header framer.
// No dependencies; imported by the framer core and its checker.
package mqtt_fhp_pkg;

  localparam int unsigned LenW    = 28;
  localparam int unsigned SizeW   = 29;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 29;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 80;

  localparam logic [LenW-1:0] LenMax = '1;

  typedef enum logic [1:0] {
    PH_CMD  = 2'd0,
    PH_LEN  = 2'd1,
    PH_PAY  = 2'd2,
    PH_HALT = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_CMD = 2'd0,
    ROLE_LEN = 2'd1,
    ROLE_PAY = 2'd2,
    ROLE_IGN = 2'd3
  } role_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOTCONNECT = 3'd1,
    ST_RESERVED   = 3'd2,
    ST_MALFORMED  = 3'd3,
    ST_OVERSIZE   = 3'd4
  } status_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PROTOCOL_V5    = 3'd0,
    REG_PEER_IS_BRIDGE = 3'd1,
    REG_CONNECT_LIMIT  = 3'd2,
    REG_SIMPLE_LIMIT   = 3'd3,
    REG_SUBSCRIBE_LIMIT = 3'd4,
    REG_AUTH_LIMIT     = 3'd5,
    REG_OVERALL_LIMIT  = 3'd6
  } reg_e;

  localparam logic [3:0] TYPE_RESERVED   = 4'h0;
  localparam logic [3:0] TYPE_CONNECT    = 4'h1;
  localparam logic [3:0] TYPE_PUBACK     = 4'h4;
  localparam logic [3:0] TYPE_PUBREC     = 4'h5;
  localparam logic [3:0] TYPE_PUBREL     = 4'h6;
  localparam logic [3:0] TYPE_PUBCOMP    = 4'h7;
  localparam logic [3:0] TYPE_SUBSCRIBE  = 4'h8;
  localparam logic [3:0] TYPE_UNSUBSCRIBE = 4'hA;
  localparam logic [3:0] TYPE_UNSUBACK   = 4'hB;
  localparam logic [3:0] TYPE_PINGREQ    = 4'hC;
  localparam logic [3:0] TYPE_PINGRESP   = 4'hD;
  localparam logic [3:0] TYPE_DISCONNECT = 4'hE;
  localparam logic [3:0] TYPE_AUTH       = 4'hF;

  typedef struct packed {
    logic            v5;
    logic [LenW-1:0] connect_lim;
    logic [LenW-1:0] simple_lim;
    logic [LenW-1:0] subscribe_lim;
    logic [LenW-1:0] auth_lim;
  } type_cfg_t;

  function automatic status_e type_check(input logic [3:0] ptype,
                                         input logic [LenW-1:0] len,
                                         input type_cfg_t cfg);
    status_e st;
    st = ST_OK;
    case (ptype)
      TYPE_CONNECT: if (len > cfg.connect_lim) st = ST_OVERSIZE;
      TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP, TYPE_UNSUBACK: begin
        if (cfg.v5) begin
          if (len > cfg.simple_lim) st = ST_OVERSIZE;
        end else if (len != LenW'(2)) begin
          st = ST_MALFORMED;
        end
      end
      TYPE_PINGREQ, TYPE_PINGRESP: if (len != '0) st = ST_MALFORMED;
      TYPE_DISCONNECT: begin
        if (cfg.v5) begin
          if (len > cfg.simple_lim) st = ST_OVERSIZE;
        end else if (len != '0) begin
          st = ST_MALFORMED;
        end
      end
      TYPE_SUBSCRIBE, TYPE_UNSUBSCRIBE: begin
        if (cfg.v5 && (len > cfg.subscribe_lim)) st = ST_OVERSIZE;
      end
      TYPE_AUTH: if (len > cfg.auth_lim) st = ST_OVERSIZE;
      default: st = ST_OK;
    endcase
    return st;
  endfunction

endpackage

/* rtl/mqtt_fixed_header_parser_core.sv */
// MQTT fixed header framer: one received byte in, one tagged byte out per beat.
// Depends on mqtt_fhp_pkg for codes, types and the per-type length rule.
//
// Usage:
//   s_axis carries one received byte per beat: tdata[7:0] rx_byte,
//   tdata[8] session_new. m_axis returns one beat for every input beat:
//   the byte, its role (tuser), the packet's command byte, the decoded
//   remaining length, the payload offset and the status; tlast marks the
//   last byte of a complete packet.
//   Each accepted byte is registered and shows on m_axis in the cycle after
//   it is accepted. Throughput is one byte per cycle while m_axis_tready
//   is high, limited by the single output register; s_axis_tready stays
//   high while the output register is empty or is being taken in the same cycle.
//   When the receiver stalls, the output beat holds and s_axis_tready drops
//   until it is taken; no beat is lost.
//   The first error is latched until reset; later bytes come out as ignored.
//   Reset returns the framer to waiting for a command byte, clears the
//   latched error and loads the register defaults. Register writes through
//   the cfg port take effect on the next byte.
module mqtt_fixed_header_parser_core
  import mqtt_fhp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] rx_byte, [8] session_new, [15:9] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] data_out, [15:8] command_byte, [43:16] length_value,
  // [71:44] payload_offset, [74:72] status, [75] disconnect_request,
  // [76] disconnect_reason, [79:77] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  // [1:0] byte_role
  output logic [1:0]          m_axis_tuser,
  output logic                m_axis_tlast
);

  logic             v5_q, bridge_q;
  logic [LenW-1:0]  connect_lim_q, simple_lim_q, subscribe_lim_q, auth_lim_q;
  logic [SizeW-1:0] overall_lim_q;
  type_cfg_t        type_cfg;

  phase_e           phase_q, phase_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [LenW-1:0]  acc_q, acc_d, left_q, left_d, pos_q, pos_d;
  logic [2:0]       cnt_q, cnt_d;
  status_e          err_q, err_d;

  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [1:0]       out_role_q;
  logic             out_last_q;

  logic             accept;
  logic [7:0]       rx_byte;
  logic             session_new;
  role_e            role;
  status_e          status;
  logic [LenW-1:0]  offset, len_out, acc_add;
  logic             pkt_end, dreq, dreason;
  logic             to_len, to_pay, to_cmd;

  assign rx_byte     = s_axis_tdata[7:0];
  assign session_new = s_axis_tdata[8];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;

  assign type_cfg = '{v5: v5_q, connect_lim: connect_lim_q, simple_lim: simple_lim_q,
                      subscribe_lim: subscribe_lim_q, auth_lim: auth_lim_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q            <= 1'b0;
      bridge_q        <= 1'b0;
      connect_lim_q   <= LenMax;
      simple_lim_q    <= LenMax;
      subscribe_lim_q <= LenMax;
      auth_lim_q      <= LenMax;
      overall_lim_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROTOCOL_V5:     v5_q            <= cfg_wdata_i[0];
        REG_PEER_IS_BRIDGE:  bridge_q        <= cfg_wdata_i[0];
        REG_CONNECT_LIMIT:   connect_lim_q   <= cfg_wdata_i[LenW-1:0];
        REG_SIMPLE_LIMIT:    simple_lim_q    <= cfg_wdata_i[LenW-1:0];
        REG_SUBSCRIBE_LIMIT: subscribe_lim_q <= cfg_wdata_i[LenW-1:0];
        REG_AUTH_LIMIT:      auth_lim_q      <= cfg_wdata_i[LenW-1:0];
        REG_OVERALL_LIMIT:   overall_lim_q   <= cfg_wdata_i[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // Length groups land in disjoint bit ranges, so OR-ing in acts as the add.
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    acc_add = LenW'(rx_byte[6:0]);
      2'd1:    acc_add = LenW'(rx_byte[6:0]) << 7;
      2'd2:    acc_add = LenW'(rx_byte[6:0]) << 14;
      default: acc_add = LenW'(rx_byte[6:0]) << 21;
    endcase
  end

  // Byte decode: role, status and datapath updates.
  always_comb begin
    role    = ROLE_IGN;
    status  = ST_OK;
    offset  = '0;
    pkt_end = 1'b0;
    dreq    = 1'b0;
    dreason = 1'b0;
    to_len  = 1'b0;
    to_pay  = 1'b0;
    to_cmd  = 1'b0;
    cmd_d   = cmd_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    pos_d   = pos_q;
    if (err_q != ST_OK) begin
      status = err_q;
    end else begin
      unique case (phase_q)
        PH_CMD: begin
          role  = ROLE_CMD;
          cmd_d = rx_byte;
          acc_d = '0;
          cnt_d = '0;
          if (!bridge_q && session_new && (rx_byte[7:4] != TYPE_CONNECT)) begin
            status = ST_NOTCONNECT;
          end else if (rx_byte[7:4] == TYPE_RESERVED) begin
            status = ST_RESERVED;
            dreq   = v5_q;
          end else begin
            to_len = 1'b1;
          end
        end
        PH_LEN: begin
          role = ROLE_LEN;
          if (cnt_q[2]) begin
            status = ST_MALFORMED;
          end else begin
            acc_d = acc_q | acc_add;
            cnt_d = cnt_q + 3'd1;
            if (!rx_byte[7]) begin
              status = type_check(cmd_q[7:4], acc_d, type_cfg);
              if ((status == ST_OK) && (overall_lim_q != '0)
                  && ({1'b0, acc_d} >= overall_lim_q)) begin
                status  = ST_OVERSIZE;
                dreq    = v5_q;
                dreason = v5_q;
              end
              if (status == ST_OK) begin
                if (acc_d == '0) begin
                  pkt_end = 1'b1;
                  to_cmd  = 1'b1;
                end else begin
                  left_d = acc_d;
                  pos_d  = '0;
                  to_pay = 1'b1;
                end
              end
            end
          end
        end
        PH_PAY: begin
          role   = ROLE_PAY;
          offset = pos_q;
          pos_d  = pos_q + LenW'(1);
          left_d = left_q - LenW'(1);
          if (left_q == LenW'(1)) begin
            pkt_end = 1'b1;
            to_cmd  = 1'b1;
          end
        end
        PH_HALT: status = err_q;
        default: status = err_q;
      endcase
    end
    len_out = (role == ROLE_CMD) ? '0 : acc_d;
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    if (to_len) phase_d = PH_LEN;
    if (to_pay) phase_d = PH_PAY;
    if (to_cmd) phase_d = PH_CMD;
    if ((err_q == ST_OK) && (status != ST_OK)) begin
      err_d   = status;
      phase_d = PH_HALT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CMD;
      err_q   <= ST_OK;
      cmd_q   <= '0;
      acc_q   <= '0;
      cnt_q   <= '0;
      left_q  <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      err_q   <= err_d;
      cmd_q   <= cmd_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {3'b000, dreason, dreq, status, offset, len_out, cmd_d, rx_byte};
      out_role_q <= role;
      out_last_q <= pkt_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_role_q;
  assign m_axis_tlast  = out_last_q;

endmodule

/* rtl/mqtt_fhp_checker.sv */
// Port-level checker for the MQTT fixed header framer, bound to its top level.
// Depends on mqtt_fhp_pkg for role and status codes.
module mqtt_fhp_checker
  import mqtt_fhp_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [1:0]          m_axis_tuser,
  input logic                m_axis_tlast
);

  logic       beat;
  logic [2:0] st;
  logic       dreq, dreason;

  assign beat    = m_axis_tvalid && m_axis_tready;
  assign st      = m_axis_tdata[74:72];
  assign dreq    = m_axis_tdata[75];
  assign dreason = m_axis_tdata[76];

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output beat changed");

  a_ignored_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && (m_axis_tuser == ROLE_IGN)) |-> (st != ST_OK))
    else $error("ignored byte without latched error");

  a_last_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && m_axis_tlast) |->
      ((st == ST_OK) && ((m_axis_tuser == ROLE_LEN) || (m_axis_tuser == ROLE_PAY))))
    else $error("packet end on wrong byte");

  a_disconnect_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && (dreq || dreason)) |->
      (dreq && ((dreason && (st == ST_OVERSIZE)) || (!dreason && (st == ST_RESERVED)))))
    else $error("disconnect request without matching status");

  a_cmd_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (beat && (m_axis_tuser == ROLE_CMD)) |->
      ((m_axis_tdata[43:16] == '0) && (m_axis_tdata[71:44] == '0)
       && (m_axis_tdata[15:8] == m_axis_tdata[7:0])))
    else $error("command byte beat carries stale fields");

endmodule

bind mqtt_fixed_header_parser_core mqtt_fhp_checker u_mqtt_fhp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
